FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the substring match counter
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant checked at every clock edge out of reset
`define SMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define SMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/smc_pkg.sv
// ----------------------------------------------------------------------------
// smc_pkg
// Types and constants of the substring match counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smc_pkg;

  // sizes
  localparam int MAX_PATTERN = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int SYM_W       = 8;
  localparam int LEN_W       = 5;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int MATCH_W     = 32;
  localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
  localparam int PIDX_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO  = 2'd0,
    REG_PAT_HI  = 2'd1,
    REG_PAT_LEN = 2'd2
  } cfg_reg_e;

  // pattern as seen by the window compare, aligned to the newest symbol
  typedef struct packed {
    logic [MAX_PATTERN-1:0][SYM_W-1:0] aligned;
    logic [MAX_PATTERN-1:0]            mask;
    logic [FILL_W-1:0]                 len;
  } cfg_t;

  // compare stage result handed to the counter
  typedef struct packed {
    logic hit;
    logic last;
  } s1_t;

endpackage

FILE: rtl/smc_if.sv
// ----------------------------------------------------------------------------
// smc_if
// Valid/ready channels of the substring match counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// symbol channel
interface smc_in_if;
  import smc_pkg::*;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last_in_line;
  logic             last_in_sequence;

  modport source (output valid, symbol, last_in_line, last_in_sequence, input ready);
  modport sink   (input valid, symbol, last_in_line, last_in_sequence, output ready);
endinterface

// result channel
interface smc_out_if;
  import smc_pkg::*;
  logic               valid;
  logic               ready;
  logic [MATCH_W-1:0] match_count;
  logic               count_saturated;

  modport source (output valid, match_count, count_saturated, input ready);
  modport sink   (input valid, match_count, count_saturated, output ready);
endinterface

FILE: rtl/smc_cfg.sv
// ----------------------------------------------------------------------------
// smc_cfg
// Pattern registers and alignment of the pattern to the symbol window
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [smc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [smc_pkg::CFG_W-1:0]      cfg_wdata_i,
  output smc_pkg::cfg_t                  cfg_o
);
  import smc_pkg::*;

  logic [CFG_W-1:0]  pat_lo_q;
  logic [CFG_W-1:0]  pat_hi_q;
  logic [FILL_W-1:0] len_q;
  logic [LEN_W-1:0]  wr_len;
  logic [FILL_W-1:0] wr_len_clamped;
  logic [2*CFG_W-1:0] pat_all;
  logic [PIDX_W-1:0] src_idx;

  // clamp written length into 1..MAX_PATTERN
  assign wr_len = cfg_wdata_i[LEN_W-1:0];
  always_comb begin
    if (wr_len == '0) begin
      wr_len_clamped = FILL_W'(1);
    end else if (wr_len > LEN_W'(MAX_PATTERN)) begin
      wr_len_clamped = FILL_W'(MAX_PATTERN);
    end else begin
      wr_len_clamped = FILL_W'(wr_len);
    end
  end

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= FILL_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PAT_LO:  pat_lo_q <= cfg_wdata_i;
        REG_PAT_HI:  pat_hi_q <= cfg_wdata_i;
        REG_PAT_LEN: len_q    <= wr_len_clamped;
        default:     ;
      endcase
    end
  end

  // byte i of the window meets pattern byte len-1-i
  assign pat_all = {pat_hi_q, pat_lo_q};
  always_comb begin
    cfg_o.len = len_q;
    src_idx   = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      src_idx           = PIDX_W'(len_q - FILL_W'(1) - FILL_W'(i));
      cfg_o.mask[i]     = (FILL_W'(i) < len_q);
      cfg_o.aligned[i]  = pat_all[SYM_W*src_idx +: SYM_W];
    end
  end

endmodule

FILE: rtl/smc_window.sv
// ----------------------------------------------------------------------------
// smc_window
// Symbol window, restart fill counter and parallel pattern compare
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smc_window (
  input  logic          clk_i,
  input  logic          rst_ni,
  smc_in_if.sink        in_if,
  input  smc_pkg::cfg_t cfg_i,
  input  logic          take_i,
  output logic          s1_valid_o,
  output smc_pkg::s1_t  s1_o
);
  import smc_pkg::*;

  logic [MAX_PATTERN-1:0][SYM_W-1:0] win_q;
  logic [MAX_PATTERN-1:0][SYM_W-1:0] win_d;
  logic [FILL_W-1:0]                 fill_q;
  logic [FILL_W-1:0]                 fill_d;
  logic [FILL_W-1:0]                 fill_inc;
  logic [MAX_PATTERN-1:0]            byte_ok;
  logic                              hit;
  logic                              in_fire;
  logic                              s1_valid_q;
  s1_t                               s1_q;

  // handshake: stage register frees when the counter takes it
  assign in_if.ready = !s1_valid_q || take_i;
  assign in_fire     = in_if.valid && in_if.ready;

  // shifted window, newest symbol at position 0
  always_comb begin
    win_d[0] = in_if.symbol;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_d[i] = win_q[i-1];
    end
  end

  // window compare against the aligned pattern
  assign fill_inc = (fill_q < FILL_W'(MAX_PATTERN)) ? fill_q + FILL_W'(1) : fill_q;
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      byte_ok[i] = !cfg_i.mask[i] || (win_d[i] == cfg_i.aligned[i]);
    end
  end
  assign hit = (fill_inc >= cfg_i.len) && (&byte_ok);

  // restart at a match, at every line end and at every sequence end
  assign fill_d = (hit || in_if.last_in_line || in_if.last_in_sequence) ? '0 : fill_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      fill_q     <= '0;
      s1_valid_q <= 1'b0;
      s1_q       <= '0;
    end else begin
      if (in_fire) begin
        win_q     <= win_d;
        fill_q    <= fill_d;
        s1_q.hit  <= hit;
        s1_q.last <= in_if.last_in_sequence;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (take_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

  // checks
  `SMC_ASSERT(a_fill_bound, fill_q <= FILL_W'(MAX_PATTERN), "restart counter past pattern size")
  `SMC_ASSERT_NEXT(a_hit_restart, in_fire && hit, fill_q == '0, "match did not restart the fill")
  `SMC_ASSERT_NEXT(a_hit_logged, in_fire && hit, s1_valid_q && s1_q.hit, "match lost at stage")

endmodule

FILE: rtl/smc_count.sv
// ----------------------------------------------------------------------------
// smc_count
// Saturating match counter and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smc_count (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s1_valid_i,
  input  smc_pkg::s1_t s1_i,
  output logic         take_o,
  smc_out_if.source    out_if
);
  import smc_pkg::*;

  logic [COUNT_WIDTH-1:0] cnt_q;
  logic [COUNT_WIDTH-1:0] cnt_d;
  logic                   sat_q;
  logic                   sat_d;
  logic                   out_valid_q;
  logic [COUNT_WIDTH-1:0] out_cnt_q;
  logic                   out_sat_q;
  logic                   s1_fire;
  logic                   res_fire;

  // a sequence end needs a free result register, other beats always pass
  assign take_o   = !s1_i.last || !out_valid_q || out_if.ready;
  assign s1_fire  = s1_valid_i && take_o;
  assign res_fire = s1_fire && s1_i.last;

  // saturating increment
  always_comb begin
    cnt_d = cnt_q;
    sat_d = sat_q;
    if (s1_i.hit) begin
      if (cnt_q == COUNT_MAX) begin
        sat_d = 1'b1;
      end else begin
        cnt_d = cnt_q + COUNT_WIDTH'(1);
      end
    end
  end

  // running count, cleared once the total is handed off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sat_q <= 1'b0;
    end else if (res_fire) begin
      cnt_q <= '0;
      sat_q <= 1'b0;
    end else if (s1_fire) begin
      cnt_q <= cnt_d;
      sat_q <= sat_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      out_cnt_q <= cnt_d;
      out_sat_q <= sat_d;
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.match_count     = MATCH_W'(out_cnt_q);
  assign out_if.count_saturated = out_sat_q;

  // checks
  `SMC_ASSERT(a_sat_at_max, !sat_q || (cnt_q == COUNT_MAX), "saturated below the maximum")
  `SMC_ASSERT_NEXT(a_result_out, res_fire, out_valid_q && (cnt_q == '0) && !sat_q,
                   "sequence end did not post a result and clear")

endmodule

FILE: rtl/substring_match_counter_top.sv
// ----------------------------------------------------------------------------
// substring_match_counter_top
// Counts non-overlapping pattern matches in a line-structured byte stream
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one symbol per beat with its line-end and sequence-end
//   flags. Matches of the configured 1 to 16 byte pattern are counted
//   greedily from the left and never cross a line end. The beat flagged as
//   sequence end produces one beat on out_if with the total and a flag
//   telling whether the count stopped at its maximum; the total then
//   restarts from zero.
//   One symbol is taken every cycle while the stage register is empty or
//   the counter takes it. The path is one window-compare stage, then the
//   counter and result register; a sequence-end beat passes both before its
//   result turns valid on out_if.
//   While a result waits on a stalled receiver, symbols keep flowing; only a
//   second sequence end halts the input until the first result is taken.
//   The user must write the pattern registers through cfg_we_i / cfg_idx_i /
//   cfg_wdata_i only while no beat is in flight; the block does not enforce
//   it. Reset clears window, count, pattern; sets the pattern length to one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module substring_match_counter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  smc_in_if.sink                        in_if,
  smc_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [smc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [smc_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import smc_pkg::*;

  cfg_t cfg;
  s1_t  s1;
  logic s1_valid;
  logic take;

  // pattern registers
  smc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // window compare stage
  smc_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .cfg_i      (cfg),
    .take_i     (take),
    .s1_valid_o (s1_valid),
    .s1_o       (s1)
  );

  // counter and result register
  smc_count u_count (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_i       (s1),
    .take_o     (take),
    .out_if     (out_if)
  );

endmodule
